FILE: design/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared types, character codes and helpers for the integer-to-ASCII
// formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

  // Conversion kinds carried in the action field
  typedef enum logic [2:0] {
    ACT_CHAR = 3'd0,
    ACT_SDEC = 3'd1,
    ACT_UDEC = 3'd2,
    ACT_HEXL = 3'd3,
    ACT_HEXU = 3'd4,
    ACT_PTR  = 3'd5,
    ACT_PCT  = 3'd6,
    ACT_NONE = 3'd7
  } action_e;

  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned TOTAL_W  = 31;
  localparam int unsigned BIN_W    = 32;  // operand width of the decimal and hex kinds
  localparam int unsigned DEC_DIGS = 10;  // decimal digits of a 32-bit value
  localparam int unsigned HEX_DIGS = 8;   // hex digits of a 32-bit value
  localparam int unsigned PTR_W    = 48;  // pointer bits that are printed
  localparam int unsigned DIG_W    = 64;  // digit shift register width

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_X       = 8'h78;  // 'x'
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;  // '-'
  localparam logic [CHAR_W-1:0] CH_PCT     = 8'h25;  // '%'
  localparam logic [CHAR_W-1:0] CASE_OFS   = 8'd32;  // lower to upper case

  localparam logic [TOTAL_W-1:0] COUNT_MAX = 31'h7fff_ffff;

  typedef struct packed {
    logic [2:0]         action;
    logic [VALUE_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  out_char;
    logic               last_char;
    logic [TOTAL_W-1:0] chars_total;
  } chr_item_t;

  // ASCII code of one hex digit
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_LOWER_A + {4'd0, d} - 8'd10;
      if (upper) begin
        c = c - CASE_OFS;
      end
    end
    return c;
  endfunction

endpackage

FILE: design/itaf_stream_if.sv
// ----------------------------------------------------------------------------
// itaf_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface itaf_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: design/integer_to_ascii_formatter.sv
// Flow: char, percent and pointer requests go from ST_IDLE straight to ST_EMIT,
// which writes each character into the output register; hex requests first pass
// ST_SKIP, which drops up to 7 leading zero digits, and decimal requests first run
// bit-serial BCD conversion in ST_CONV, then ST_SKIP with up to 9 drops.
// Throughput: one character per cycle while the sink holds ready; one request at a time.
// Reset clears the running character count and empties the output register.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one conversion request into ASCII characters, one per transaction,
// flags the last one and keeps a saturating count of all characters sent.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
  import itaf_pkg::*;
#(
  parameter int unsigned POINTER_HEX_DIGITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  itaf_stream_if.sink   req_i,
  itaf_stream_if.source chr_o
);

  localparam int unsigned MAX_DIGS  = (POINTER_HEX_DIGITS > DEC_DIGS) ?
                                      POINTER_HEX_DIGITS : DEC_DIGS;
  localparam int unsigned NDIG_W    = $clog2(MAX_DIGS + 1);
  localparam int unsigned STEP_W    = $clog2(BIN_W);
  localparam int unsigned PTR_SHIFT = 4 * (16 - POINTER_HEX_DIGITS);
  localparam int unsigned BCD_W     = 4 * DEC_DIGS;
  localparam int unsigned BCD_LO    = DIG_W - BCD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  state_e                state_q;
  logic [DIG_W-1:0]      dig_q;
  logic [BIN_W-1:0]      bin_q;
  logic [STEP_W-1:0]     step_q;
  logic [NDIG_W-1:0]     ndig_q;
  logic [2*CHAR_W-1:0]   pre_q;
  logic [1:0]            pre_n_q;
  logic                  upper_q;
  logic [TOTAL_W-1:0]    cnt_q;
  logic                  ovalid_q;
  chr_item_t             out_q;

  req_item_t             req;
  logic [BIN_W-1:0]      v32;
  logic [BIN_W-1:0]      mag;
  logic [BCD_W-1:0]      bcd_adj;
  logic                  out_free;
  logic [CHAR_W-1:0]     emit_char;
  logic                  emit_last;
  logic [TOTAL_W-1:0]    cnt_inc;
  logic [DIG_W-1:0]      ptr_dig;

  assign req      = req_i.payload;
  assign v32      = req.value[BIN_W-1:0];
  assign mag      = (req.action == ACT_SDEC && v32[BIN_W-1]) ? (~v32 + 32'd1) : v32;
  assign ptr_dig  = {{(DIG_W-PTR_W){1'b0}}, req.value[PTR_W-1:0]} << PTR_SHIFT;
  assign out_free = !ovalid_q || chr_o.ready;
  assign cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 31'd1;

  // Add three to every BCD digit of five or more before the next shift
  always_comb begin
    for (int k = 0; k < DEC_DIGS; k++) begin
      bcd_adj[4*k +: 4] = (dig_q[BCD_LO + 4*k +: 4] >= 4'd5) ?
                          dig_q[BCD_LO + 4*k +: 4] + 4'd3 :
                          dig_q[BCD_LO + 4*k +: 4];
    end
  end

  // Next character: prefix bytes first, then digits from the top nibble
  always_comb begin
    if (pre_n_q != 2'd0) begin
      emit_char = pre_q[2*CHAR_W-1 -: CHAR_W];
      emit_last = (pre_n_q == 2'd1) && (ndig_q == '0);
    end else begin
      emit_char = hex_char(dig_q[DIG_W-1 -: 4], upper_q);
      emit_last = (ndig_q == NDIG_W'(1));
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign chr_o.valid   = ovalid_q;
  assign chr_o.payload = out_q;

  // Sequencer, digit shift register and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      dig_q    <= '0;
      bin_q    <= '0;
      step_q   <= '0;
      ndig_q   <= '0;
      pre_q    <= '0;
      pre_n_q  <= '0;
      upper_q  <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      out_q    <= '0;
    end else begin
      // drop the output once taken; a new character may replace it below
      if (chr_o.ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            upper_q <= (req.action == ACT_HEXU);
            pre_n_q <= 2'd0;
            ndig_q  <= '0;
            step_q  <= '0;
            case (req.action)
              ACT_CHAR: begin
                pre_q   <= {req.value[CHAR_W-1:0], CH_ZERO};
                pre_n_q <= 2'd1;
                state_q <= ST_EMIT;
              end
              ACT_SDEC, ACT_UDEC: begin
                pre_q   <= {CH_MINUS, CH_ZERO};
                pre_n_q <= {1'b0, (req.action == ACT_SDEC) && v32[BIN_W-1]};
                bin_q   <= mag;
                dig_q   <= '0;
                ndig_q  <= NDIG_W'(DEC_DIGS);
                state_q <= ST_CONV;
              end
              ACT_HEXL, ACT_HEXU: begin
                dig_q   <= {v32, {(DIG_W-BIN_W){1'b0}}};
                ndig_q  <= NDIG_W'(HEX_DIGS);
                state_q <= ST_SKIP;
              end
              ACT_PTR: begin
                pre_q   <= {CH_ZERO, CH_X};
                pre_n_q <= 2'd2;
                dig_q   <= ptr_dig;
                ndig_q  <= NDIG_W'(POINTER_HEX_DIGITS);
                state_q <= ST_EMIT;
              end
              ACT_PCT: begin
                pre_q   <= {CH_PCT, CH_ZERO};
                pre_n_q <= 2'd1;
                state_q <= ST_EMIT;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CONV: begin
          // shift one binary bit into the BCD digits per cycle
          dig_q  <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1], {BCD_LO{1'b0}}};
          bin_q  <= {bin_q[BIN_W-2:0], 1'b0};
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(BIN_W - 1)) begin
            state_q <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zero digits, keeping at least one
          if (ndig_q > NDIG_W'(1) && dig_q[DIG_W-1 -: 4] == 4'd0) begin
            dig_q  <= {dig_q[DIG_W-5:0], 4'd0};
            ndig_q <= ndig_q - NDIG_W'(1);
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            ovalid_q          <= 1'b1;
            out_q.out_char    <= emit_char;
            out_q.last_char   <= emit_last;
            out_q.chars_total <= cnt_inc;
            cnt_q             <= cnt_inc;
            if (pre_n_q != 2'd0) begin
              pre_q   <= {pre_q[CHAR_W-1:0], CH_ZERO};
              pre_n_q <= pre_n_q - 2'd1;
            end else begin
              dig_q  <= {dig_q[DIG_W-5:0], 4'd0};
              ndig_q <= ndig_q - NDIG_W'(1);
            end
            if (emit_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/itaf_checker.sv
// ----------------------------------------------------------------------------
// itaf_checker
// Port-level assertions for the integer-to-ASCII formatter, bound to the top.
// ----------------------------------------------------------------------------
module itaf_checker
  import itaf_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid,
  input logic      in_ready,
  input req_item_t in_payload,
  input logic      out_valid,
  input logic      out_ready,
  input chr_item_t out_payload
);

  // Hold a stalled character transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled character changed or dropped");

  // Take no request while a request still has characters to send
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_payload.last_char |-> !in_ready)
    else $error("request accepted mid-conversion");

  // Busy after any request that produces characters
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_payload.action != ACT_NONE |=> !in_ready)
    else $error("formatter ready right after a request");

  // Every character counts itself
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_payload.chars_total != '0)
    else $error("character sent with zero running total");

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (req_i.valid),
  .in_ready    (req_i.ready),
  .in_payload  (req_i.payload),
  .out_valid   (chr_o.valid),
  .out_ready   (chr_o.ready),
  .out_payload (chr_o.payload)
);

FILE: tb/tb_integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter
// Self-checking bench for the integer-to-ASCII formatter. A queue-fed driver
// sends conversion requests and a clocked checker compares every character
// with a predicted string. The run covers directed corner values for each
// kind, then random requests with random idling on both channels and at
// least one pause that lets all outstanding characters drain.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter;
  import itaf_pkg::*;

  localparam int unsigned PTR_DIGITS   = 12;
  localparam int unsigned RANDOM_ITEMS = 70;
  localparam int unsigned BLOCK_ITEMS  = 20;
  localparam int unsigned TAIL_CYCLES  = 64;

  typedef struct packed {
    req_item_t req;
    logic      drain_first;  // hold this request until all characters are out
  } pending_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  itaf_stream_if #(.payload_t(req_item_t)) req_if ();
  itaf_stream_if #(.payload_t(chr_item_t)) chr_if ();

  integer_to_ascii_formatter #(
    .POINTER_HEX_DIGITS(PTR_DIGITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .chr_o (chr_if.source)
  );

  pending_req_t       pending_reqs[$];
  chr_item_t          expected_chars[$];
  logic [TOTAL_W-1:0] char_tally = '0;
  logic               req_taken = 1'b0;
  logic               chr_taken = 1'b0;
  bit                 idle_en = 1'b1;
  int                 req_wait = 0;
  int                 chr_wait = 0;
  int                 queued_total = 0;
  int                 accepted = 0;
  int                 directed_total = 0;
  int                 chars_checked = 0;
  int                 mismatches = 0;
  int                 kind_count[8];

  // Free-running clock, 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Give up after a generous bound
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int draw_gap();
    return idle_en ? int'($urandom_range(0, 5)) : 0;
  endfunction

  // Build the character string of one request and queue its characters
  function automatic void predict_conversion(req_item_t req);
    logic [CHAR_W-1:0] text[$];
    logic [31:0]       word;
    logic [63:0]       ptr;
    logic [3:0]        nibble;
    string             digits;
    string             hex_lower;
    chr_item_t         c;
    hex_lower = "0123456789abcdef";
    word      = req.value[31:0];
    ptr       = req.value & 64'h0000_ffff_ffff_ffff;
    digits    = "";
    case (action_e'(req.action))
      ACT_CHAR: text.push_back(req.value[7:0]);
      ACT_SDEC: begin
        if (word[31]) begin
          text.push_back(CH_MINUS);
          digits = $sformatf("%0d", 32'd0 - word);
        end else begin
          digits = $sformatf("%0d", word);
        end
      end
      ACT_UDEC: digits = $sformatf("%0d", word);
      ACT_HEXL: begin
        digits = $sformatf("%0h", word);
        digits = digits.tolower();
      end
      ACT_HEXU: begin
        digits = $sformatf("%0h", word);
        digits = digits.toupper();
      end
      ACT_PTR: begin
        text.push_back(CH_ZERO);
        text.push_back(CH_X);
        for (int i = PTR_DIGITS - 1; i >= 0; i--) begin
          nibble = 4'((ptr >> (4 * (i % 16))) & 64'hf);
          text.push_back(hex_lower.getc(nibble));
        end
      end
      ACT_PCT: text.push_back(CH_PCT);
      default: ;
    endcase
    for (int i = 0; i < digits.len(); i++) begin
      text.push_back(digits.getc(i));
    end
    // Advance the saturating count once per character
    foreach (text[i]) begin
      if (char_tally != COUNT_MAX) begin
        char_tally = char_tally + 1'b1;
      end
      c.out_char    = text[i];
      c.last_char   = (i == text.size() - 1);
      c.chars_total = char_tally;
      expected_chars.push_back(c);
    end
  endfunction

  // Operand with a mix of magnitudes so leading-zero removal varies
  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: v[31:0] = v[31:0] >> $urandom_range(0, 31);
      1: v[31:0] = $urandom_range(0, 20);
      2: v[31:0] = 32'd0 - $urandom_range(1, 20);
      3: v[47:0] = v[47:0] >> $urandom_range(0, 47);
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_req(input action_e act, input logic [63:0] val, input bit drain);
    pending_req_t p;
    p.req.action  = act;
    p.req.value   = val;
    p.drain_first = drain;
    pending_reqs.push_back(p);
    queued_total++;
  endtask

  // Hold until every queued request is taken and every character is out
  task automatic wait_quiet();
    do begin
      @(negedge clk_i);
    end while (accepted != queued_total || expected_chars.size() != 0);
    @(posedge clk_i);
  endtask

  // Request driver: hold valid until taken, then idle for a drawn gap
  always @(negedge clk_i) begin : req_driver
    pending_req_t nxt;
    if (rst_ni) begin
      if (req_taken) begin
        req_wait = draw_gap();
      end
      if (req_if.valid && !req_taken) begin
        // hold the current transaction
      end else if (req_wait > 0) begin
        req_wait--;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   !(pending_reqs[0].drain_first && expected_chars.size() > 0)) begin
        nxt = pending_reqs.pop_front();
        req_if.payload <= nxt.req;
        req_if.valid   <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Character sink: stall for a drawn number of cycles after each transaction
  always @(negedge clk_i) begin : chr_ready_driver
    if (rst_ni) begin
      if (chr_taken) begin
        chr_wait = draw_gap();
      end
      if (chr_wait > 0) begin
        chr_wait--;
        chr_if.ready <= 1'b0;
      end else begin
        chr_if.ready <= 1'b1;
      end
    end
  end

  // Predict on each accepted request, check each accepted character
  always @(posedge clk_i) begin : char_checker
    chr_item_t want;
    chr_item_t got;
    if (rst_ni) begin
      req_taken <= req_if.valid && req_if.ready;
      chr_taken <= chr_if.valid && chr_if.ready;
      if (req_if.valid && req_if.ready) begin
        predict_conversion(req_if.payload);
        kind_count[req_if.payload.action]++;
        accepted++;
      end
      if (chr_if.valid && chr_if.ready) begin
        got = chr_if.payload;
        chars_checked++;
        if (expected_chars.size() == 0) begin
          $error("unexpected character: out_char=%h last_char=%b chars_total=%0d",
                 got.out_char, got.last_char, got.chars_total);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (got.out_char !== want.out_char) begin
            $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
            mismatches++;
          end
          if (got.last_char !== want.last_char) begin
            $error("last_char: expected %b, actual %b", want.last_char, got.last_char);
            mismatches++;
          end
          if (got.chars_total !== want.chars_total) begin
            $error("chars_total: expected %0d, actual %0d",
                   want.chars_total, got.chars_total);
            mismatches++;
          end
        end
      end
    end
  end

  // Stimulus: reset, directed corners, then random blocks
  initial begin
    action_e act;
    int      n;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    chr_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    foreach (kind_count[i]) kind_count[i] = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners of every kind
    queue_req(ACT_CHAR, 64'h0, 1'b0);
    queue_req(ACT_CHAR, 64'hffff_ffff_ffff_ffff, 1'b0);
    queue_req(ACT_CHAR, 64'h1234_5678_9abc_de41, 1'b0);
    queue_req(ACT_SDEC, 64'h0, 1'b0);
    queue_req(ACT_SDEC, 64'h1, 1'b0);
    queue_req(ACT_SDEC, 64'hffff_ffff_ffff_ffff, 1'b0);
    queue_req(ACT_SDEC, 64'h0000_0000_8000_0000, 1'b0);
    queue_req(ACT_SDEC, 64'hffff_ffff_7fff_ffff, 1'b0);
    queue_req(ACT_UDEC, 64'hffff_ffff_0000_0000, 1'b0);
    queue_req(ACT_UDEC, 64'h0000_0000_ffff_ffff, 1'b0);
    queue_req(ACT_UDEC, 64'h0000_0000_3b9a_ca00, 1'b0);
    queue_req(ACT_HEXL, 64'h0, 1'b0);
    queue_req(ACT_HEXL, 64'hffff_ffff_ffff_ffff, 1'b0);
    queue_req(ACT_HEXL, 64'h5555_0000_dead_beef, 1'b0);
    queue_req(ACT_HEXU, 64'h0000_0000_abcd_ef01, 1'b0);
    queue_req(ACT_HEXU, 64'h0000_0000_0000_000a, 1'b0);
    queue_req(ACT_PTR,  64'h0, 1'b0);
    queue_req(ACT_PTR,  64'hffff_ffff_ffff_ffff, 1'b0);
    queue_req(ACT_PTR,  64'h0000_1234_5678_9abc, 1'b0);
    queue_req(ACT_PCT,  64'hffff_ffff_ffff_ffff, 1'b0);
    queue_req(ACT_NONE, 64'h0123_4567_89ab_cdef, 1'b0);
    queue_req(ACT_PCT,  64'h0, 1'b0);
    directed_total = queued_total;
    wait_quiet();

    // Random blocks; the second one runs without idling
    n = 0;
    for (int blk = 0; n < RANDOM_ITEMS; blk++) begin
      idle_en = (blk % 4 != 1);
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        n_loop: begin
          int unsigned r;
          r   = $urandom_range(0, 14);
          act = (r == 14) ? ACT_NONE : action_e'(r % 7);
          queue_req(act, random_operand(), n == RANDOM_ITEMS / 2);
          if (act != ACT_NONE) n++;
        end
      end
      wait_quiet();
    end

    // Let any late output show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Summary: %0d requests (%0d directed), %0d characters checked, final count %0d",
             accepted, directed_total, chars_checked, char_tally);
    $display("Mix: char %0d, sdec %0d, udec %0d, hexl %0d, hexu %0d, ptr %0d, pct %0d, none %0d",
             kind_count[ACT_CHAR], kind_count[ACT_SDEC], kind_count[ACT_UDEC],
             kind_count[ACT_HEXL], kind_count[ACT_HEXU], kind_count[ACT_PTR],
             kind_count[ACT_PCT], kind_count[ACT_NONE]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/itaf_pkg.sv
design/itaf_stream_if.sv
design/integer_to_ascii_formatter.sv
design/itaf_checker.sv
tb/tb_integer_to_ascii_formatter.sv
